### design/rrtq_pkg.sv
// Package: shared constants, types and helpers for the round-robin thread queue.
package rrtq_pkg;

  localparam int MAX_THREADS = 16;
  localparam int ID_BITS     = 16;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  localparam int FIFO_DEPTH  = 2;
  localparam int FPTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADMIT  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEXT   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_SCAN,
    ES_SHIFT,
    ES_PICK
  } eng_state_e;

  typedef struct packed {
    op_e                op;
    logic [ID_BITS-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic [ID_BITS-1:0] picked_id;
    logic               picked_valid;
    status_e            status;
    logic [CNT_W-1:0]   count;
  } res_t;

  // Physical slot of logical position off in the ring starting at base.
  function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(MAX_THREADS)) begin
      sum = sum - (CNT_W + 1)'(MAX_THREADS);
    end
    return IDX_W'(sum);
  endfunction

endpackage

### design/rrtq_front.sv
// Front end: accepts and classifies requests into a short command queue.
module rrtq_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    operation_i,
  input  logic [15:0]                   thread_id_i,
  output logic                          cmd_valid_o,
  output rrtq_pkg::cmd_t                cmd_o,
  input  logic                          cmd_pop_i
);

  rrtq_pkg::cmd_t                    slot_q [rrtq_pkg::FIFO_DEPTH];
  logic [rrtq_pkg::FPTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [rrtq_pkg::FCNT_W-1:0]       cnt_q, cnt_d;
  rrtq_pkg::cmd_t                    dec;
  logic                              do_push, do_pop;

  always_comb begin
    dec.id = rrtq_pkg::ID_BITS'(thread_id_i);
    // every 2-bit code names an operation; the unused code is a no-op
    dec.op = rrtq_pkg::op_e'(operation_i);
  end

  assign full        = (cnt_q == rrtq_pkg::FCNT_W'(rrtq_pkg::FIFO_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == rrtq_pkg::FPTR_W'(rrtq_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == rrtq_pkg::FPTR_W'(rrtq_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= dec;
    end
  end

endmodule

### design/rrtq_back.sv
// Back end: executes commands on the ring of thread IDs held in a slot memory.
module rrtq_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  rrtq_pkg::cmd_t       cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 res_space_i,
  output logic                 res_push_o,
  output rrtq_pkg::res_t       res_o
);

  rrtq_pkg::eng_state_e              state_q, state_d;
  logic [rrtq_pkg::IDX_W-1:0]        head_q, head_d;
  logic [rrtq_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [rrtq_pkg::CNT_W-1:0]        idx_q, idx_d;
  logic [rrtq_pkg::IDX_W-1:0]        wr_q, wr_d;
  logic                              pend_q, pend_d;
  rrtq_pkg::op_e                     op_q, op_d;
  logic [rrtq_pkg::ID_BITS-1:0]      id_q, id_d;

  logic [rrtq_pkg::ID_BITS-1:0]      mem_q [rrtq_pkg::MAX_THREADS];
  logic [rrtq_pkg::ID_BITS-1:0]      rdata_q, wdata;
  logic [rrtq_pkg::IDX_W-1:0]        raddr, waddr;
  logic                              we, hit;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign hit = pend_q && (rdata_q == id_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    wr_d       = wr_q;
    pend_d     = 1'b0;
    op_d       = op_q;
    id_d       = id_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{picked_id: '0, picked_valid: 1'b0, status: rrtq_pkg::ST_OK, count: cnt_q};
    raddr      = rrtq_pkg::ring_idx(head_q, idx_q);
    waddr      = rrtq_pkg::ring_idx(head_q, cnt_q);
    wdata      = id_q;
    we         = 1'b0;

    unique case (state_q)
      rrtq_pkg::ES_IDLE: begin
        if (cmd_valid_i && res_space_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          id_d      = cmd_i.id;
          idx_d     = '0;
          unique case (cmd_i.op)
            rrtq_pkg::OP_ADMIT: begin
              if (cnt_q >= rrtq_pkg::CNT_W'(rrtq_pkg::MAX_THREADS)) begin
                res_push_o   = 1'b1;
                res_o.status = rrtq_pkg::ST_FULL;
              end else begin
                state_d = rrtq_pkg::ES_SCAN;
              end
            end
            rrtq_pkg::OP_REMOVE: state_d = rrtq_pkg::ES_SCAN;
            rrtq_pkg::OP_NEXT: begin
              if (cnt_q == '0) begin
                res_push_o   = 1'b1;
                res_o.status = rrtq_pkg::ST_EMPTY;
              end else begin
                raddr   = head_q;
                state_d = rrtq_pkg::ES_PICK;
              end
            end
            default: res_push_o = 1'b1;
          endcase
        end
      end

      rrtq_pkg::ES_SCAN: begin
        // reads run one slot ahead of the compare
        if (hit) begin
          if (op_q == rrtq_pkg::OP_ADMIT) begin
            res_push_o   = 1'b1;
            res_o.status = rrtq_pkg::ST_DUPLICATE;
            state_d      = rrtq_pkg::ES_IDLE;
          end else begin
            // idx_q already points one past the match
            state_d = rrtq_pkg::ES_SHIFT;
          end
        end else if (idx_q == cnt_q) begin
          res_push_o = 1'b1;
          state_d    = rrtq_pkg::ES_IDLE;
          if (op_q == rrtq_pkg::OP_ADMIT) begin
            we          = 1'b1;
            cnt_d       = cnt_q + 1'b1;
            res_o.count = cnt_q + 1'b1;
          end else begin
            res_o.status = rrtq_pkg::ST_NOT_FOUND;
          end
        end else begin
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end
      end

      rrtq_pkg::ES_SHIFT: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = rrtq_pkg::ring_idx(head_q, rrtq_pkg::CNT_W'(wr_q));
          wdata = rdata_q;
        end
        if (idx_q < cnt_q) begin
          pend_d = 1'b1;
          wr_d   = rrtq_pkg::IDX_W'(idx_q - 1'b1);
          idx_d  = idx_q + 1'b1;
        end else begin
          cnt_d       = cnt_q - 1'b1;
          res_push_o  = 1'b1;
          res_o.count = cnt_q - 1'b1;
          state_d     = rrtq_pkg::ES_IDLE;
        end
      end

      rrtq_pkg::ES_PICK: begin
        // head rotates to the tail
        we                 = 1'b1;
        wdata              = rdata_q;
        head_d             = rrtq_pkg::ring_idx(head_q, rrtq_pkg::CNT_W'(1));
        res_push_o         = 1'b1;
        res_o.picked_id    = rdata_q;
        res_o.picked_valid = 1'b1;
        state_d            = rrtq_pkg::ES_IDLE;
      end

      default: state_d = rrtq_pkg::ES_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrtq_pkg::ES_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    wr_q  <= wr_d;
    op_q  <= op_d;
    id_q  <= id_d;
  end

endmodule

### design/rrtq_out.sv
// Result queue: holds finished results until the consumer pops them.
module rrtq_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_push_i,
  input  rrtq_pkg::res_t       res_i,
  output logic                 res_space_o,
  output logic                 empty,
  input  logic                 pop,
  output rrtq_pkg::res_t       res_o
);

  rrtq_pkg::res_t                    slot_q [rrtq_pkg::FIFO_DEPTH];
  logic [rrtq_pkg::FPTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [rrtq_pkg::FCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign res_space_o = (cnt_q != rrtq_pkg::FCNT_W'(rrtq_pkg::FIFO_DEPTH));
  assign empty       = (cnt_q == '0);
  assign res_o       = slot_q[rd_q];
  assign do_push     = res_push_i && res_space_o;
  assign do_pop      = pop && !empty;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == rrtq_pkg::FPTR_W'(rrtq_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == rrtq_pkg::FPTR_W'(rrtq_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= res_i;
    end
  end

endmodule

### design/round_robin_thread_queue_top.sv
// Top level: round-robin ready queue of thread IDs.
//
//   channel   handshake         payload
//   request   push / full       operation_i, thread_id_i
//   result    empty / pop       picked_id_o, picked_valid_o, status_o, queue_count_o
//
// A transaction waits in the command queue until the engine is idle and a result slot
// is free; its result reaches the ports once older results are popped. No-op, full and
// empty are answered from idle; next moves the head to the tail; admit and remove scan
// the queue, a duplicate admit stops at its match and a remove hit shifts later IDs down.
// Slot memory reads are registered. Reset empties the queue; slots stay undefined. A
// stalled result side stops the engine only when both result slots are taken.
module round_robin_thread_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [15:0] thread_id_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] picked_id_o,
  output logic        picked_valid_o,
  output logic [2:0]  status_o,
  output logic [4:0]  queue_count_o
);

  logic           cmd_valid, cmd_pop, res_space, res_push;
  rrtq_pkg::cmd_t cmd;
  rrtq_pkg::res_t res_in, res_out;

  rrtq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .thread_id_i (thread_id_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rrtq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_space_i (res_space),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  rrtq_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_push_i  (res_push),
    .res_i       (res_in),
    .res_space_o (res_space),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_out)
  );

  assign picked_id_o    = 16'(res_out.picked_id);
  assign picked_valid_o = res_out.picked_valid;
  assign status_o       = 3'(res_out.status);
  assign queue_count_o  = 5'(res_out.count);

endmodule

### design/rrtq_checker.sv
// Checker: port-level properties of the round-robin thread queue, bound to the top.
module rrtq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [15:0] picked_id_o,
  input logic        picked_valid_o,
  input logic [2:0]  status_o,
  input logic [4:0]  queue_count_o
);

  a_pick_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && picked_valid_o) |-> (status_o == 3'(rrtq_pkg::ST_OK)))
    else $error("picked transaction without ok status");

  a_no_pick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !picked_valid_o) |-> (picked_id_o == '0))
    else $error("nonzero picked_id without a pick");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == 3'(rrtq_pkg::ST_EMPTY)) |-> (queue_count_o == '0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == 3'(rrtq_pkg::ST_FULL)) |->
      (queue_count_o == 5'(rrtq_pkg::MAX_THREADS)))
    else $error("full status with count below capacity");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(queue_count_o)))
    else $error("stalled result transaction changed");

endmodule

bind round_robin_thread_queue_top rrtq_checker u_rrtq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .picked_id_o    (picked_id_o),
  .picked_valid_o (picked_valid_o),
  .status_o       (status_o),
  .queue_count_o  (queue_count_o)
);

### tb/tb.sv
// Self-checking testbench for the round-robin thread queue.
`timescale 1ns / 100ps

module tb;

  // Predicts every result from the request stream and checks the results in order.
  class thread_queue_score;
    logic [rrtq_pkg::ID_BITS-1:0] ready_q[$];
    rrtq_pkg::res_t               due[$];
    int                           errors;
    int                           checked;
    int                           by_status[8];

    function new();
      errors  = 0;
      checked = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("tb: mismatch at %0t: %s want %0h got %0h", $realtime, what, want, got);
    endtask

    function void apply_request(rrtq_pkg::op_e op, logic [rrtq_pkg::ID_BITS-1:0] id);
      rrtq_pkg::res_t               r;
      int                           pos;
      bit                           dup;
      logic [rrtq_pkg::ID_BITS-1:0] head;
      r        = '0;
      r.status = rrtq_pkg::ST_OK;
      case (op)
        rrtq_pkg::OP_ADMIT: begin
          dup = 1'b0;
          foreach (ready_q[i]) if (ready_q[i] == id) dup = 1'b1;
          if (ready_q.size() >= rrtq_pkg::MAX_THREADS) begin
            r.status = rrtq_pkg::ST_FULL;
          end else if (dup) begin
            r.status = rrtq_pkg::ST_DUPLICATE;
          end else begin
            ready_q.push_back(id);
          end
        end
        rrtq_pkg::OP_REMOVE: begin
          // search runs from the tail toward the head
          pos = -1;
          for (int i = ready_q.size() - 1; i >= 0; i--) begin
            if (ready_q[i] == id) begin
              pos = i;
              break;
            end
          end
          if (pos < 0) begin
            r.status = rrtq_pkg::ST_NOT_FOUND;
          end else begin
            ready_q.delete(pos);
          end
        end
        rrtq_pkg::OP_NEXT: begin
          if (ready_q.size() == 0) begin
            r.status = rrtq_pkg::ST_EMPTY;
          end else begin
            head = ready_q.pop_front();
            ready_q.push_back(head);
            r.picked_id    = head;
            r.picked_valid = 1'b1;
          end
        end
        default: ;
      endcase
      r.count = rrtq_pkg::CNT_W'(ready_q.size());
      due.push_back(r);
    endfunction

    task check_result(logic [15:0] pid, logic pv, logic [2:0] st, logic [4:0] cnt);
      rrtq_pkg::res_t want;
      checked++;
      if (due.size() == 0) begin
        report("result with no request outstanding", 32'(0), 32'(st));
        return;
      end
      want = due.pop_front();
      by_status[want.status]++;
      if (pid !== want.picked_id) begin
        report("picked_id", 32'(want.picked_id), 32'(pid));
      end
      if (pv !== want.picked_valid) begin
        report("picked_valid", 32'(want.picked_valid), 32'(pv));
      end
      if (st !== 3'(want.status)) begin
        report("status", 32'(want.status), 32'(st));
      end
      if (cnt !== want.count) begin
        report("queue_count", 32'(want.count), 32'(cnt));
      end
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [1:0]  operation_i = 2'd0;
  logic [15:0] thread_id_i = 16'd0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [15:0] picked_id_o;
  logic        picked_valid_o;
  logic [2:0]  status_o;
  logic [4:0]  queue_count_o;

  thread_queue_score sb = new();
  bit                quiet = 1'b0;
  int                n_sent = 0;
  logic [15:0]       id_pool[24];

  round_robin_thread_queue_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .thread_id_i    (thread_id_i),
    .empty          (empty),
    .pop            (pop),
    .picked_id_o    (picked_id_o),
    .picked_valid_o (picked_valid_o),
    .status_o       (status_o),
    .queue_count_o  (queue_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Holds the request until the queue takes it; push stays high for a back-to-back request.
  task automatic send(rrtq_pkg::op_e op, logic [15:0] id);
    push        <= 1'b1;
    operation_i <= op;
    thread_id_i <= id;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.apply_request(op, id);
    n_sent++;
  endtask

  task automatic idle_in(int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop sending until every outstanding transaction has come back.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.due.size() != 0);
  endtask

  function automatic logic [15:0] any_id();
    if ($urandom_range(0, 99) < 15) return 16'($urandom_range(0, 65535));
    return id_pool[$urandom_range(0, 23)];
  endfunction

  task automatic random_request(int admit_pct);
    int            r;
    rrtq_pkg::op_e op;
    logic [15:0]   id;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      op = rrtq_pkg::OP_NOP;
      id = 16'($urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < admit_pct) begin
        op = rrtq_pkg::OP_ADMIT;
        id = any_id();
      end else if (r < admit_pct + (100 - admit_pct) / 2) begin
        op = rrtq_pkg::OP_REMOVE;
        if (sb.ready_q.size() != 0 && $urandom_range(0, 99) < 75) begin
          id = sb.ready_q[$urandom_range(0, sb.ready_q.size() - 1)];
        end else begin
          id = any_id();
        end
      end else begin
        op = rrtq_pkg::OP_NEXT;
        id = 16'($urandom);
      end
    end
    send(op, id);
  endtask

  // Result side: random stalls on pop, check at every accepted transaction.
  initial begin
    int stall;
    stall = 0;
    wait (rst_ni);
    forever begin
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop   <= 1'b1;
        stall = gap_len();
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_result(picked_id_o, picked_valid_o, status_o, queue_count_o);
      end
    end
  end

  initial begin
    int admit_pct;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 24; i++) id_pool[i] = 16'($urandom_range(0, 65535));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, no-op code, extreme IDs, duplicate, misses
    send(rrtq_pkg::OP_NEXT, 16'h0000);
    send(rrtq_pkg::OP_REMOVE, 16'h0000);
    send(rrtq_pkg::OP_NOP, 16'hFFFF);
    send(rrtq_pkg::OP_ADMIT, 16'h0000);
    send(rrtq_pkg::OP_ADMIT, 16'hFFFF);
    send(rrtq_pkg::OP_ADMIT, 16'hFFFF);
    send(rrtq_pkg::OP_NEXT, 16'hFFFF);
    send(rrtq_pkg::OP_REMOVE, 16'h1234);
    send(rrtq_pkg::OP_REMOVE, 16'h0000);
    // fill up to capacity, then hit full with a new and with a queued ID
    for (int i = 0; i < rrtq_pkg::MAX_THREADS - 1; i++) begin
      send(rrtq_pkg::OP_ADMIT, 16'h0001 << i);
    end
    send(rrtq_pkg::OP_ADMIT, 16'h8000);
    send(rrtq_pkg::OP_ADMIT, 16'hFFFF);
    send(rrtq_pkg::OP_NEXT, 16'h0000);
    send(rrtq_pkg::OP_REMOVE, 16'h0100);
    drain();

    // random: blocks that lean toward filling, draining or balance
    for (int blk = 0; blk < 34; blk++) begin
      case ($urandom_range(0, 2))
        0:       admit_pct = 15;
        1:       admit_pct = 45;
        default: admit_pct = 85;
      endcase
      quiet = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < 50; k++) begin
        random_request(admit_pct);
        idle_in(gap_len());
      end
      if ($urandom_range(0, 7) == 0) drain();
    end

    quiet = 1'b0;
    drain();
    repeat (40) @(posedge clk_i);

    $display("tb: %0d requests, %0d results checked", n_sent, sb.checked);
    $display("tb: ok %0d, empty %0d, full %0d, not found %0d, duplicate %0d",
             sb.by_status[rrtq_pkg::ST_OK], sb.by_status[rrtq_pkg::ST_EMPTY],
             sb.by_status[rrtq_pkg::ST_FULL], sb.by_status[rrtq_pkg::ST_NOT_FOUND],
             sb.by_status[rrtq_pkg::ST_DUPLICATE]);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
